// ===== sv/humidity_temp_frame_decoder_unit_assert.svh =====
// assertion macros for the humidity / temperature frame decoder
// used by the checker module; no other dependencies
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define HMTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hmtd assertion failed");

// condition must hold in the cycle after the trigger
`define HMTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hmtd assertion failed");

`endif

// ===== sv/hmtd_pkg.sv =====
// shared constants, types and the crc-8 step function for the frame decoder
// no dependencies
package hmtd_pkg;

    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [7:0]  CRC_POLY   = 8'h31;

    localparam logic [2:0]  POS_HUM_MSB = 3'd0;
    localparam logic [2:0]  POS_HUM_LSB = 3'd1;
    localparam logic [2:0]  POS_HUM_CRC = 3'd2;
    localparam logic [2:0]  POS_TMP_MSB = 3'd3;
    localparam logic [2:0]  POS_TMP_LSB = 3'd4;
    localparam logic [2:0]  POS_TMP_CRC = 3'd5;

    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TMP_SCALE   = 15'd17500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic signed [15:0] TMP_OFFSET = 16'sd4500;
    localparam logic signed [14:0] TMP_MIN    = -15'sd4500;
    localparam logic signed [14:0] TMP_MAX    = 15'sd13000;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_HUM_CRC = 2'd1,
        ERR_TMP_CRC = 2'd2
    } t_err;

    typedef struct packed {
        logic [15:0] hum_raw;
        logic [15:0] tmp_raw;
        logic        ok;
        t_err        err;
    } t_frame;

    // one byte through the msb-first crc-8 register
    function automatic logic [7:0] crc_feed(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/hmtd_if.sv =====
// valid/ready channel interfaces for the frame decoder
// depends on nothing but plain logic
interface hmtd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface hmtd_out_if;
    logic               valid;
    logic               ready;
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;
    logic               data_valid;
    logic [1:0]         error_code;

    modport source (output valid, output humidity_centi, output temperature_centi,
                    output data_valid, output error_code, input ready);
    modport sink   (input valid, input humidity_centi, input temperature_centi,
                    input data_valid, input error_code, output ready);
endinterface

// ===== sv/hmtd_frame.sv =====
// byte position tracking, crc checking and raw reading capture
// depends on hmtd_pkg and hmtd_in_if
module hmtd_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hmtd_in_if.sink         i_in,
    input  logic            i_frm_rdy,
    output logic            o_frm_vld,
    output hmtd_pkg::t_frame o_frm
);
    import hmtd_pkg::*;

    logic [2:0]  r_pos,  n_pos;
    logic [7:0]  r_crc,  n_crc;
    logic [7:0]  r_msb,  n_msb;
    logic [15:0] r_hum,  n_hum;
    logic [15:0] r_tmp,  n_tmp;
    logic        r_hok,  n_hok;
    logic        r_fvld, n_fvld;
    t_frame      r_frm,  n_frm;

    logic        accept;
    logic [2:0]  pos;
    logic [7:0]  crc_next;
    logic        crc_match;

    assign i_in.ready = !r_fvld || i_frm_rdy;
    assign accept     = i_in.valid && i_in.ready;

    // frame start forces position zero; unused codes restart too
    assign pos       = (i_in.frame_start || r_pos > POS_TMP_CRC) ? POS_HUM_MSB : r_pos;
    assign crc_next  = crc_feed((pos == POS_HUM_MSB || pos == POS_TMP_MSB) ? CRC_INIT : r_crc,
                                i_in.data_byte);
    assign crc_match = (r_crc == i_in.data_byte);

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_msb  = r_msb;
        n_hum  = r_hum;
        n_tmp  = r_tmp;
        n_hok  = r_hok;
        n_fvld = r_fvld && !i_frm_rdy;
        n_frm  = r_frm;
        if (accept) begin
            case (pos)
                POS_HUM_MSB, POS_TMP_MSB: begin
                    n_crc = crc_next;
                    n_msb = i_in.data_byte;
                    n_pos = pos + 3'd1;
                end
                POS_HUM_LSB: begin
                    n_crc = crc_next;
                    n_hum = {r_msb, i_in.data_byte};
                    n_pos = POS_HUM_CRC;
                end
                POS_HUM_CRC: begin
                    n_hok = crc_match;
                    n_crc = CRC_INIT;
                    n_pos = POS_TMP_MSB;
                end
                POS_TMP_LSB: begin
                    n_crc = crc_next;
                    n_tmp = {r_msb, i_in.data_byte};
                    n_pos = POS_TMP_CRC;
                end
                default: begin
                    n_crc         = CRC_INIT;
                    n_pos         = POS_HUM_MSB;
                    n_fvld        = 1'b1;
                    n_frm.hum_raw = r_hum;
                    n_frm.tmp_raw = r_tmp;
                    n_frm.ok      = r_hok && crc_match;
                    n_frm.err     = !r_hok ? ERR_HUM_CRC : (!crc_match ? ERR_TMP_CRC : ERR_NONE);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HUM_MSB;
            r_crc  <= CRC_INIT;
            r_hok  <= 1'b0;
            r_fvld <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_hok  <= n_hok;
            r_fvld <= n_fvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msb <= n_msb;
        r_hum <= n_hum;
        r_tmp <= n_tmp;
        r_frm <= n_frm;
    end

    assign o_frm_vld = r_fvld;
    assign o_frm     = r_frm;

endmodule

// ===== sv/hmtd_scale.sv =====
// fixed-point scaling of the raw readings into the output register
// depends on hmtd_pkg and hmtd_out_if
module hmtd_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_frm_vld,
    input  hmtd_pkg::t_frame i_frm,
    output logic             o_frm_rdy,
    hmtd_out_if.source       o_out
);
    import hmtd_pkg::*;

    logic [29:0]        hum_prod;
    logic [13:0]        hum_q0;
    logic [16:0]        hum_rem;
    logic [13:0]        hum_q;
    logic [30:0]        tmp_prod;
    logic [14:0]        tmp_q0;
    logic [16:0]        tmp_rem;
    logic [14:0]        tmp_q;
    logic signed [15:0] tmp_c;
    logic               advance;

    logic               r_vld, n_vld;
    logic [13:0]        r_hum, n_hum;
    logic signed [14:0] r_tmp, n_tmp;
    logic               r_ok,  n_ok;
    logic [1:0]         r_err, n_err;

    // x / 65535: take x >> 16, remainder is low half plus that quotient, one correction
    assign hum_prod = 30'(i_frm.hum_raw) * 30'(HUM_SCALE);
    assign hum_q0   = hum_prod[29:16];
    assign hum_rem  = 17'(hum_prod[15:0]) + 17'(hum_q0);
    assign hum_q    = hum_q0 + 14'(hum_rem >= FULL_SCALE);

    assign tmp_prod = 31'(i_frm.tmp_raw) * 31'(TMP_SCALE);
    assign tmp_q0   = tmp_prod[30:16];
    assign tmp_rem  = 17'(tmp_prod[15:0]) + 17'(tmp_q0);
    assign tmp_q    = tmp_q0 + 15'(tmp_rem >= FULL_SCALE);
    assign tmp_c    = $signed({1'b0, tmp_q}) - TMP_OFFSET;

    assign advance   = !r_vld || o_out.ready;
    assign o_frm_rdy = advance;

    always_comb begin
        n_vld = advance ? i_frm_vld : r_vld;
        n_hum = r_hum;
        n_tmp = r_tmp;
        n_ok  = r_ok;
        n_err = r_err;
        if (advance && i_frm_vld) begin
            n_ok  = i_frm.ok;
            n_err = i_frm.ok ? ERR_NONE : i_frm.err;
            n_hum = i_frm.ok ? hum_q : '0;
            n_tmp = i_frm.ok ? tmp_c[14:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hum <= n_hum;
        r_tmp <= n_tmp;
        r_ok  <= n_ok;
        r_err <= n_err;
    end

    assign o_out.valid             = r_vld;
    assign o_out.humidity_centi    = r_hum;
    assign o_out.temperature_centi = r_tmp;
    assign o_out.data_valid        = r_ok;
    assign o_out.error_code        = r_err;

endmodule

// ===== sv/humidity_temp_frame_decoder_unit.sv =====
// top level of the humidity / temperature frame decoder
// depends on hmtd_pkg, hmtd_if, hmtd_frame and hmtd_scale
//
//   channel   dir   word contents
//   -------   ---   -----------------------------------------------------------
//   i_in      in    data_byte (8), frame_start (1)
//   o_out     out   humidity_centi (14), temperature_centi (15 signed),
//                   data_valid (1), error_code (2)
//
// one input word per cycle is taken while the input is not stalled; only the sixth byte of a frame makes a result
// after its closing byte a result is registered in the frame register, then in the output register
// the multiply-and-correct paths in the scaling stage set the clock limit
// reset is synchronous and active low: byte position zero, crc preset, both stages empty
// a stalled output holds its word; input stalls only when both stages are full
module humidity_temp_frame_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmtd_in_if.sink    i_in,
    hmtd_out_if.source o_out
);
    import hmtd_pkg::*;

    // frame stage to scaling stage
    logic   frm_vld;
    logic   frm_rdy;
    t_frame frm;

    // byte assembly: position counter, running crc, captured readings
    hmtd_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_frm_rdy (frm_rdy),
        .o_frm_vld (frm_vld),
        .o_frm     (frm)
    );

    // conversion to centi-units and the output register
    hmtd_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frm_vld (frm_vld),
        .i_frm     (frm),
        .o_frm_rdy (frm_rdy),
        .o_out     (o_out)
    );

endmodule

// ===== sv/hmtd_chk.sv =====
// port-level checker for the frame decoder, bound to the top level
// depends on hmtd_pkg and the assertion macro header
`include "humidity_temp_frame_decoder_unit_assert.svh"

module hmtd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [13:0]        i_hum,
    input logic signed [14:0] i_tmp,
    input logic               i_dvalid,
    input logic [1:0]         i_err
);
    import hmtd_pkg::*;

    // stalled word holds
    `HMTD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_hum) && $stable(i_tmp) && $stable(i_dvalid) && $stable(i_err))

    // failed frame: zero readings and a crc error code
    `HMTD_ASSERT_NOW(a_bad, i_clk, i_rst_n, i_out_valid && !i_dvalid, i_hum == '0 && i_tmp == '0 && (i_err == ERR_HUM_CRC || i_err == ERR_TMP_CRC))

    // good frame: no error and readings in range
    `HMTD_ASSERT_NOW(a_good, i_clk, i_rst_n, i_out_valid && i_dvalid, i_err == ERR_NONE && i_hum <= HUM_SCALE && i_tmp >= TMP_MIN && i_tmp <= TMP_MAX)

endmodule

bind humidity_temp_frame_decoder_unit hmtd_chk u_hmtd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hum       (o_out.humidity_centi),
    .i_tmp       (o_out.temperature_centi),
    .i_dvalid    (o_out.data_valid),
    .i_err       (o_out.error_code)
);

// ===== tb/tb.sv =====
// self-checking bench for humidity_temp_frame_decoder_unit: streams measurement replies
// byte by byte and checks every decoded reading against a cycle-free predictor
// depends on hmtd_pkg, hmtd_if and the decoder rtl
module tb;
    import hmtd_pkg::*;

    localparam int DIR_ROWS     = 26;
    localparam int RAND_ITEMS   = 650;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [13:0]        hum;
        logic signed [14:0] tmp;
        logic               ok;
        t_err               err;
    } reading_t;

    typedef struct {
        logic [7:0] b;
        logic       fs;
        bit         typed;
        reading_t   want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    hmtd_in_if  in_ch ();
    hmtd_out_if out_ch ();

    humidity_temp_frame_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor copy of the decoder state
    logic [2:0]  frame_pos;
    logic [7:0]  word_crc;
    logic [7:0]  msb_latch;
    logic [15:0] hum_word;
    logic [15:0] tmp_word;
    logic        hum_crc_good;

    reading_t reading_q [$];
    int       fault_cnt;
    int       seen_cnt;
    int       items_sent;
    bit       src_calm;
    bit       snk_calm;

    // directed words; typed readings only where they are plain to see
    stim_row_t dir_rows [DIR_ROWS] = '{
        // all-zero words with good checks: lowest readings
        '{8'h00, 1'b1, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h81, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h81, 1'b0, 1'b1, '{14'd0, -15'sd4500, 1'b1, ERR_NONE}},
        // full-scale words, no frame start: position wraps by itself
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hAC, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hAC, 1'b0, 1'b1, '{14'd10000, 15'sd13000, 1'b1, ERR_NONE}},
        // partial frame, dropped by the next frame start
        '{8'hBE, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hEF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        // both checks fail: humidity reported
        '{8'h00, 1'b1, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b1, '{14'd0, 15'sd0, 1'b0, ERR_HUM_CRC}},
        // temperature check fails alone
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'hAC, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '{14'd0, 15'sd0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b1, '{14'd0, 15'sd0, 1'b0, ERR_TMP_CRC}}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // crc-8, feedback taken one data bit at a time, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void clear_predictor();
        frame_pos    = POS_HUM_MSB;
        word_crc     = CRC_INIT;
        msb_latch    = 8'd0;
        hum_word     = 16'd0;
        tmp_word     = 16'd0;
        hum_crc_good = 1'b0;
    endfunction

    // advances the predictor by one word; returns 1 when a reading is due
    function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                       output reading_t r);
        logic [2:0]  pos;
        logic        tmp_good;
        logic [31:0] hum_s;
        logic [31:0] tmp_s;
        int          t;
        pos   = fs ? POS_HUM_MSB : frame_pos;
        r.hum = 14'd0;
        r.tmp = 15'sd0;
        r.ok  = 1'b0;
        r.err = ERR_NONE;
        if (pos > POS_TMP_CRC) begin
            pos = POS_HUM_MSB;
        end
        case (pos)
            POS_HUM_MSB, POS_TMP_MSB: begin
                word_crc  = crc8_step(CRC_INIT, b);
                msb_latch = b;
                frame_pos = pos + 3'd1;
                return 1'b0;
            end
            POS_HUM_LSB: begin
                word_crc  = crc8_step(word_crc, b);
                hum_word  = {msb_latch, b};
                frame_pos = POS_HUM_CRC;
                return 1'b0;
            end
            POS_HUM_CRC: begin
                hum_crc_good = (word_crc == b);
                word_crc     = CRC_INIT;
                frame_pos    = POS_TMP_MSB;
                return 1'b0;
            end
            POS_TMP_LSB: begin
                word_crc  = crc8_step(word_crc, b);
                tmp_word  = {msb_latch, b};
                frame_pos = POS_TMP_CRC;
                return 1'b0;
            end
            default: begin
                tmp_good  = (word_crc == b);
                word_crc  = CRC_INIT;
                frame_pos = POS_HUM_MSB;
                if (hum_crc_good && tmp_good) begin
                    hum_s = ({16'd0, hum_word} * 32'(HUM_SCALE)) / 32'(FULL_SCALE);
                    tmp_s = ({16'd0, tmp_word} * 32'(TMP_SCALE)) / 32'(FULL_SCALE);
                    t     = int'(tmp_s) - int'(TMP_OFFSET);
                    r.hum = hum_s[13:0];
                    r.tmp = 15'(t);
                    r.ok  = 1'b1;
                end else begin
                    r.err = hum_crc_good ? ERR_TMP_CRC : ERR_HUM_CRC;
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic int hold_cycles(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // biased towards the ends of the range
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            3:       return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // one word across the input channel, returns at the accepting edge
    task automatic put_byte(input logic [7:0] b, input logic fs);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
        end
        gap = hold_cycles(src_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.frame_start <= fs;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic fs);
        reading_t r;
        put_byte(b, fs);
        if (decode_byte(b, fs, r)) begin
            reading_q.push_back(r);
        end
    endtask

    // holds the input idle until every expected reading has been taken
    task automatic drain_readings();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (reading_q.size() != 0);
    endtask

    // one reply frame with random content; some are damaged, cut short or replaced by noise
    task automatic send_frame(inout bit resync);
        logic [15:0] hw;
        logic [15:0] tw;
        logic [7:0]  hc;
        logic [7:0]  tc;
        logic [7:0]  fr [6];
        int          kind;
        int          cut;
        kind = $urandom_range(0, 99);
        if (kind >= 96) begin
            repeat ($urandom_range(1, 4)) begin
                feed_byte(8'($urandom), ($urandom_range(0, 3) == 0));
            end
            resync = 1'b1;
            return;
        end
        hw = pick_word();
        tw = pick_word();
        hc = crc8_step(crc8_step(CRC_INIT, hw[15:8]), hw[7:0]);
        tc = crc8_step(crc8_step(CRC_INIT, tw[15:8]), tw[7:0]);
        if (kind >= 70 && kind < 80) begin
            hc ^= 8'($urandom_range(1, 255));
        end else if (kind >= 80 && kind < 85) begin
            tc ^= 8'($urandom_range(1, 255));
        end else if (kind >= 85 && kind < 90) begin
            hc ^= 8'($urandom_range(1, 255));
            tc ^= 8'($urandom_range(1, 255));
        end
        fr  = '{hw[15:8], hw[7:0], hc, tw[15:8], tw[7:0], tc};
        cut = (kind >= 90) ? $urandom_range(1, 5) : 6;
        for (int i = 0; i < cut; i++) begin
            feed_byte(fr[i], (i == 0) ? (resync | 1'($urandom_range(0, 1))) : 1'b0);
        end
        resync = (cut < 6);
    endtask

    // result side: random stalls, every reading compared with the oldest expectation
    initial begin
        int       stall;
        reading_t want;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                snk_calm = !snk_calm;
            end
            stall = hold_cycles(snk_calm);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && i_rst_n === 1'b1));
            seen_cnt++;
            if (reading_q.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10) begin
                    $display("reading %0d arrived with nothing expected", seen_cnt);
                end
            end else begin
                want = reading_q.pop_front();
                if (out_ch.humidity_centi !== want.hum || out_ch.temperature_centi !== want.tmp
                        || out_ch.data_valid !== want.ok || out_ch.error_code !== want.err) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("reading %0d: expected hum %0d tmp %0d ok %0b err %0d, got hum %0d tmp %0d ok %0b err %0d",
                                 seen_cnt, want.hum, want.tmp, want.ok, want.err,
                                 out_ch.humidity_centi, out_ch.temperature_centi,
                                 out_ch.data_valid, out_ch.error_code);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("humidity_temp_frame_decoder_unit: mismatch");
        $finish;
    end

    initial begin
        reading_t r;
        bit       resync;
        bit       paused;
        fault_cnt  = 0;
        seen_cnt   = 0;
        items_sent = 0;
        src_calm   = 1'b0;
        snk_calm   = 1'b0;
        resync     = 1'b1;
        paused     = 1'b0;
        clear_predictor();
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= 8'd0;
        in_ch.frame_start <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            put_byte(dir_rows[i].b, dir_rows[i].fs);
            if (decode_byte(dir_rows[i].b, dir_rows[i].fs, r)) begin
                reading_q.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
            end
        end
        drain_readings();

        while (items_sent < DIR_ROWS + RAND_ITEMS) begin
            send_frame(resync);
            if (!paused && items_sent > DIR_ROWS + RAND_ITEMS / 2) begin
                drain_readings();
                paused = 1'b1;
            end
        end

        drain_readings();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0 && reading_q.size() == 0) begin
            $display("humidity_temp_frame_decoder_unit: match");
        end else begin
            $display("humidity_temp_frame_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
